>>> design/sdsp_pkg.sv
// -----------------------------------------------------------------------------
// sdsp_pkg
// Shared types and constants for the stereo DAC sample pacer.
// -----------------------------------------------------------------------------
package sdsp_pkg;

   // Queue geometry
   localparam int QUEUE_DEPTH = 1024;
   localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
   localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

   // Field widths
   localparam int SAMPLE_W = 8;
   localparam int COUNT_W  = 64;
   localparam int BLOCK_W  = 11;
   localparam int REG_W    = 26;
   localparam int PHASE_W  = 27;
   localparam int CSR_IDX_W = 2;

   // Reset values and fixed offsets
   localparam logic [REG_W-1:0]    STEP_RESET  = REG_W'(1000000);
   localparam logic [REG_W-1:0]    LIMIT_RESET = REG_W'(33570145);
   localparam logic [SAMPLE_W-1:0] DAC_OFFSET  = 8'h80;
   localparam logic [BLOCK_W-1:0]  BLOCK_MAX   = 11'd2047;

   typedef enum logic [2:0] {
      ACT_TICK  = 3'd0,
      ACT_PUSH  = 3'd1,
      ACT_SET   = 3'd2,
      ACT_START = 3'd3,
      ACT_STOP  = 3'd4
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PHASE_STEP  = 2'd0,
      CSR_PHASE_LIMIT = 2'd1
   } csr_index_type;

   // One queue entry
   typedef struct packed {
      logic                blk_end;
      logic [SAMPLE_W-1:0] right;
      logic [SAMPLE_W-1:0] left;
   } pair_type;

   // Item passed from the control stage to the result stage
   typedef struct packed {
      logic               update;
      logic               dropped;
      logic               blk_clear;
      logic               blk_push_inc;
      logic [COUNT_W-1:0] count;
   } stage_type;

endpackage

>>> design/sdsp_ifs.sv
// -----------------------------------------------------------------------------
// sdsp channel interfaces
// Request, response and register-write channels with valid/ready handshake.
// -----------------------------------------------------------------------------
interface sdsp_req_if
   import sdsp_pkg::*;
   ();
   logic                       valid;
   logic                       ready;
   logic [2:0]                 action;
   logic signed [SAMPLE_W-1:0] left_sample;
   logic signed [SAMPLE_W-1:0] right_sample;
   logic                       block_end;
   logic [COUNT_W-1:0]         new_count;

   modport source (output valid, action, left_sample, right_sample, block_end, new_count,
                   input ready);
   modport sink (input valid, action, left_sample, right_sample, block_end, new_count,
                 output ready);
endinterface

interface sdsp_rsp_if
   import sdsp_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] dac_left;
   logic [SAMPLE_W-1:0] dac_right;
   logic                dac_update;
   logic [COUNT_W-1:0]  sample_count;
   logic [BLOCK_W-1:0]  blocks_waiting;
   logic                push_dropped;

   modport source (output valid, dac_left, dac_right, dac_update, sample_count,
                   blocks_waiting, push_dropped, input ready);
   modport sink (input valid, dac_left, dac_right, dac_update, sample_count,
                 blocks_waiting, push_dropped, output ready);
endinterface

interface sdsp_csr_if
   import sdsp_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [REG_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> design/stereo_dac_sample_pacer.sv
// -----------------------------------------------------------------------------
// stereo_dac_sample_pacer
// Tick-paced stereo 8-bit sample queue with fractional tick dropping.
// -----------------------------------------------------------------------------
// Usage:
//   req_bus carries one action per transfer: tick, push pair, set sample
//   count, start or stop, with the pair fields and the count value.
//   rsp_bus returns exactly one result per request: the DAC codes (held
//   between updates), the update flag, the 64-bit sample count, the number
//   of blocks still waiting and the dropped-push flag.
//   csr_bus, always ready, writes phase_step (index 0) and phase_limit
//   (index 1); the user must write it only while idle (not enforced).
// Pipeline and throughput:
//   A request transfer lands in the input register, is processed by the
//   control stage as it moves into the result register, and is offered on
//   rsp_bus from the result register. While rsp_bus is ready, one request
//   per cycle is taken sustained; the queue memory has one write port and
//   one registered read port, so no item waits on another.
// Reset: the queue is empty, the block is stopped, the counters and phase
//   are zero and both DAC codes sit at mid-scale.
// Stall: when rsp_bus is not ready the result register holds, the input
//   register fills, and req_bus ready drops only once both are occupied.
// -----------------------------------------------------------------------------
module stereo_dac_sample_pacer
   import sdsp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   sdsp_req_if.sink   req_bus,
   sdsp_rsp_if.source rsp_bus,
   sdsp_csr_if.sink   csr_bus
);

   // Control stage to result stage
   logic      stage_valid;
   logic      stage_ready;
   stage_type stage;
   pair_type  rd_pair;

   // Input register, queue and pacing state; advance on each free result slot
   sdsp_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .csr         (csr_bus),
      .stage_valid (stage_valid),
      .stage_ready (stage_ready),
      .stage       (stage),
      .rd_pair     (rd_pair)
   );

   // Result register; hold the codes and block count between transfers
   sdsp_out u_out (
      .clock       (clock),
      .reset       (reset),
      .stage_valid (stage_valid),
      .stage_ready (stage_ready),
      .stage       (stage),
      .rd_pair     (rd_pair),
      .rsp         (rsp_bus)
   );

endmodule

>>> design/sdsp_ctrl.sv
// -----------------------------------------------------------------------------
// sdsp_ctrl
// Input register, queue memory, pointers, tick phase and played counter.
// -----------------------------------------------------------------------------
module sdsp_ctrl
   import sdsp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   sdsp_req_if.sink          req,
   sdsp_csr_if.sink          csr,
   output logic              stage_valid,
   input  logic              stage_ready,
   output stage_type         stage,
   output pair_type          rd_pair
);

   // Input register
   logic                 s1_ff;
   action_type           act_ff;
   pair_type             pair_ff;
   logic [COUNT_W-1:0]   new_count_ff;

   // Registers
   logic [REG_W-1:0]     step_ff, limit_ff;

   // Control state
   logic [ADDR_W-1:0]    rd_idx_ff, rd_idx_in;
   logic [ADDR_W-1:0]    wr_idx_ff, wr_idx_in;
   logic [FILL_W-1:0]    fill_ff, fill_in;
   logic [PHASE_W-1:0]   phase_ff, phase_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 running_ff, running_in;
   logic                 in_block_ff, in_block_in;
   logic                 wr_en;

   pair_type             mem [QUEUE_DEPTH];
   pair_type             rd_pair_ff;

   logic                 advance;
   logic                 req_xfer;
   logic                 tick_ok;
   logic [PHASE_W:0]     sum;
   logic [PHASE_W:0]     sum_sub;
   logic                 skip;
   logic                 queue_full;

   function automatic logic [ADDR_W-1:0] next_idx(input logic [ADDR_W-1:0] idx);
      return (idx == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
   endfunction

   assign advance   = s1_ff && stage_ready;
   assign req.ready = !s1_ff || stage_ready;
   assign req_xfer  = req.valid && req.ready;
   assign csr.ready = 1'b1;

   assign stage_valid = s1_ff;
   assign rd_pair     = rd_pair_ff;

   assign tick_ok    = running_ff && (fill_ff != '0);
   assign sum        = {1'b0, phase_ff} + (PHASE_W + 1)'(step_ff);
   assign sum_sub    = sum - (PHASE_W + 1)'(limit_ff);
   assign skip       = sum >= (PHASE_W + 1)'(limit_ff);
   assign queue_full = fill_ff >= FILL_W'(QUEUE_DEPTH);

   always_comb begin
      rd_idx_in   = rd_idx_ff;
      wr_idx_in   = wr_idx_ff;
      fill_in     = fill_ff;
      phase_in    = phase_ff;
      count_in    = count_ff;
      running_in  = running_ff;
      in_block_in = in_block_ff;
      wr_en       = 1'b0;
      stage       = '0;

      unique case (act_ff)
         ACT_TICK: begin
            if (tick_ok) begin
               if (skip) begin
                  phase_in = sum_sub[PHASE_W-1:0];
               end else begin
                  phase_in     = sum[PHASE_W-1:0];
                  count_in     = count_ff + 1'b1;
                  rd_idx_in    = next_idx(rd_idx_ff);
                  fill_in      = fill_ff - 1'b1;
                  stage.update = 1'b1;
               end
            end
         end
         ACT_PUSH: begin
            if (queue_full) begin
               stage.dropped = 1'b1;
            end else begin
               stage.blk_push_inc = !in_block_ff;
               in_block_in        = !pair_ff.blk_end;
               wr_en              = advance;
               wr_idx_in          = next_idx(wr_idx_ff);
               fill_in            = fill_ff + 1'b1;
            end
         end
         ACT_SET: begin
            count_in = new_count_ff;
         end
         ACT_START: begin
            count_in = '0;
            if (!running_ff) begin
               phase_in        = '0;
               rd_idx_in       = '0;
               wr_idx_in       = '0;
               fill_in         = '0;
               in_block_in     = 1'b0;
               running_in      = 1'b1;
               stage.blk_clear = 1'b1;
            end
         end
         ACT_STOP: begin
            running_in      = 1'b0;
            rd_idx_in       = '0;
            wr_idx_in       = '0;
            fill_in         = '0;
            in_block_in     = 1'b0;
            stage.blk_clear = 1'b1;
         end
         default: begin
         end
      endcase

      stage.count = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= 1'b0;
      end else if (req_xfer) begin
         s1_ff <= 1'b1;
      end else if (advance) begin
         s1_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         act_ff          <= action_type'(req.action);
         pair_ff.left    <= req.left_sample;
         pair_ff.right   <= req.right_sample;
         pair_ff.blk_end <= req.block_end;
         new_count_ff    <= req.new_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= STEP_RESET;
         limit_ff <= LIMIT_RESET;
      end else if (csr.valid) begin
         if (csr.index == CSR_PHASE_STEP) begin
            step_ff <= csr.data;
         end else if (csr.index == CSR_PHASE_LIMIT) begin
            limit_ff <= csr.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff   <= '0;
         wr_idx_ff   <= '0;
         fill_ff     <= '0;
         phase_ff    <= '0;
         count_ff    <= '0;
         running_ff  <= 1'b0;
         in_block_ff <= 1'b0;
      end else if (advance) begin
         rd_idx_ff   <= rd_idx_in;
         wr_idx_ff   <= wr_idx_in;
         fill_ff     <= fill_in;
         phase_ff    <= phase_in;
         count_ff    <= count_in;
         running_ff  <= running_in;
         in_block_ff <= in_block_in;
      end
   end

   // Queue memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx_ff] <= pair_ff;
      end
      if (advance) begin
         rd_pair_ff <= mem[rd_idx_ff];
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(QUEUE_DEPTH))
      else $error("queue fill above depth");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      fill_ff == '0 |-> rd_idx_ff == wr_idx_ff)
      else $error("empty queue with unequal pointers");

   a_full_ptrs: assert property (@(posedge clock) disable iff (reset)
      fill_ff == FILL_W'(QUEUE_DEPTH) |-> rd_idx_ff == wr_idx_ff)
      else $error("full queue with unequal pointers");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      advance && stage.update |-> running_ff && fill_ff != '0)
      else $error("pop from empty or stopped queue");

endmodule

>>> design/sdsp_out.sv
// -----------------------------------------------------------------------------
// sdsp_out
// Result register: block count, held DAC codes and response handshake.
// -----------------------------------------------------------------------------
module sdsp_out
   import sdsp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      stage_valid,
   output logic      stage_ready,
   input  stage_type stage,
   input  pair_type  rd_pair,
   sdsp_rsp_if.source rsp
);

   logic                s2_ff;
   stage_type           stage_ff;
   logic [BLOCK_W-1:0]  blk_ff, blk_in;
   logic [SAMPLE_W-1:0] held_left_ff, held_right_ff;
   logic                rsp_xfer;

   assign stage_ready = !s2_ff || rsp.ready;
   assign rsp_xfer    = rsp.valid && rsp.ready;

   // Apply this item's single block-count change
   always_comb begin
      blk_in = blk_ff;
      priority if (stage_ff.blk_clear) begin
         blk_in = '0;
      end else if (stage_ff.update && rd_pair.blk_end && blk_ff != '0) begin
         blk_in = blk_ff - 1'b1;
      end else if (stage_ff.blk_push_inc && blk_ff < BLOCK_MAX) begin
         blk_in = blk_ff + 1'b1;
      end else begin
         blk_in = blk_ff;
      end
   end

   assign rsp.valid          = s2_ff;
   assign rsp.dac_left       = stage_ff.update ? (rd_pair.left ^ DAC_OFFSET) : held_left_ff;
   assign rsp.dac_right      = stage_ff.update ? (rd_pair.right ^ DAC_OFFSET) : held_right_ff;
   assign rsp.dac_update     = stage_ff.update;
   assign rsp.sample_count   = stage_ff.count;
   assign rsp.blocks_waiting = blk_in;
   assign rsp.push_dropped   = stage_ff.dropped;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff <= 1'b0;
      end else if (stage_ready) begin
         s2_ff <= stage_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_valid && stage_ready) begin
         stage_ff <= stage;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blk_ff        <= '0;
         held_left_ff  <= DAC_OFFSET;
         held_right_ff <= DAC_OFFSET;
      end else if (rsp_xfer) begin
         blk_ff        <= blk_in;
         held_left_ff  <= rsp.dac_left;
         held_right_ff <= rsp.dac_right;
      end
   end

   a_one_blk_op: assert property (@(posedge clock) disable iff (reset)
      s2_ff |-> $countones({stage_ff.blk_clear, stage_ff.blk_push_inc, stage_ff.update,
                            stage_ff.dropped}) <= 1)
      else $error("more than one queue operation in one item");

   a_held_codes: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer |=> held_left_ff == $past(rsp.dac_left))
      else $error("held left code lost");

   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      s2_ff && stage_ff.blk_clear |-> rsp.blocks_waiting == '0)
      else $error("block count not cleared");

endmodule
